// ----- rtl/paf_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// paf_pkg
// Shared types, character codes and helpers for the PAF line parser.
// -----------------------------------------------------------------------------
package paf_pkg;

	localparam logic [3:0] MIN_FIELDS = 4'd12;
	localparam int         FIFO_AW    = 2;
	localparam int         FIFO_DEPTH = 1 << FIFO_AW;

	localparam logic [3:0] FLD_QLEN   = 4'd1;
	localparam logic [3:0] FLD_QSTART = 4'd2;
	localparam logic [3:0] FLD_QEND   = 4'd3;
	localparam logic [3:0] FLD_RESID  = 4'd9;
	localparam logic [3:0] FLD_BLOCK  = 4'd10;
	localparam logic [3:0] FLD_MAPQ   = 4'd11;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_P     = "P";
	localparam logic [7:0] CH_I     = "I";
	localparam logic [7:0] CH_D     = "D";

	// prefix matcher: 0 idle, 1..4 inside the prefix, 5 and 6 value states, 7 dead
	localparam logic [2:0] PM_IDLE        = 3'd0;
	localparam logic [2:0] PM_FIRST       = 3'd1;
	localparam logic [2:0] PM_VALUE_FIRST = 3'd5;
	localparam logic [2:0] PM_VALUE       = 3'd6;
	localparam logic [2:0] PM_DEAD        = 3'd7;

	typedef enum logic [2:0] {
		TAG_NONE = 3'd0,
		TAG_TP   = 3'd1,
		TAG_CG   = 3'd2,
		TAG_NM   = 3'd3,
		TAG_AS   = 3'd4
	} tag_kind_t;

	typedef enum logic [1:0] {
		NP_PRE    = 2'd0,
		NP_DIGITS = 2'd1,
		NP_STOP   = 2'd2
	} num_phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_ZERO_POS = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] text;
		logic       last;
		logic       is_tab;
		logic       is_digit;
		logic [3:0] dval;
		logic       is_space;
		logic       is_sign;
		logic       is_minus;
		logic       is_p;
		logic       is_ins;
		logic       is_del;
		tag_kind_t  first_kind;
	} tok_t;

	typedef struct packed {
		logic               fields_ok;
		logic [30:0]        qlen;
		logic signed [31:0] qstart;
		logic signed [31:0] qend;
		logic [7:0]         mapq;
		logic [30:0]        resid;
		logic [30:0]        block;
		logic               prim;
		logic [15:0]        ins;
		logic [15:0]        del;
		logic [30:0]        edit;
		logic signed [31:0] score;
	} snap_t;

	function automatic logic [7:0] tag_char(input tag_kind_t kind, input logic [2:0] pos);
		logic [39:0] txt;
		begin
			unique case (kind)
				TAG_TP:  txt = "tp:A:";
				TAG_CG:  txt = "cg:Z:";
				TAG_NM:  txt = "NM:i:";
				TAG_AS:  txt = "AS:i:";
				default: txt = '0;
			endcase
			unique case (pos)
				3'd0:    tag_char = txt[39:32];
				3'd1:    tag_char = txt[31:24];
				3'd2:    tag_char = txt[23:16];
				3'd3:    tag_char = txt[15:8];
				3'd4:    tag_char = txt[7:0];
				default: tag_char = 8'h00;
			endcase
		end
	endfunction

	// magnitude and sign to int32, clamped
	function automatic logic signed [31:0] num_value(input logic [63:0] mag, input logic neg);
		logic [31:0] m;
		begin
			if (neg) begin
				m = (mag > 64'd2147483648) ? 32'h8000_0000 : mag[31:0];
				num_value = -m;
			end else begin
				num_value = (mag > 64'd2147483647) ? 32'h7FFF_FFFF : mag[31:0];
			end
		end
	endfunction

	function automatic logic [30:0] clamp31(input logic signed [31:0] v);
		clamp31 = v[31] ? 31'd0 : v[30:0];
	endfunction

	function automatic logic [7:0] clamp8(input logic signed [31:0] v);
		logic [7:0] r;
		begin
			if (v[31])
				r = 8'd0;
			else if (v > 32'sd255)
				r = 8'hFF;
			else
				r = v[7:0];
			clamp8 = r;
		end
	endfunction

endpackage

// ----- rtl/paf_ifs.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// paf_ifs
// Valid/ready channels for text bytes in and alignment records out.
// -----------------------------------------------------------------------------
interface paf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       line_last;

	modport source (output valid, output text_byte, output line_last, input ready);
	modport sink   (input valid, input text_byte, input line_last, output ready);
endinterface

interface paf_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [30:0]        query_length;
	logic signed [31:0] aligned_span;
	logic [7:0]         mapping_quality;
	logic [30:0]        residue_matches;
	logic [30:0]        block_length;
	logic               primary;
	logic [15:0]        variant_total;
	logic [15:0]        ins_runs;
	logic [15:0]        del_runs;
	logic [30:0]        edit_distance;
	logic signed [31:0] alignment_score;

	modport source (
		output valid, status, query_length, aligned_span, mapping_quality,
		output residue_matches, block_length, primary, variant_total,
		output ins_runs, del_runs, edit_distance, alignment_score,
		input ready
	);
	modport sink (
		input valid, status, query_length, aligned_span, mapping_quality,
		input residue_matches, block_length, primary, variant_total,
		input ins_runs, del_runs, edit_distance, alignment_score,
		output ready
	);
endinterface

// ----- rtl/paf_front.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// paf_front
// Classifies incoming text bytes and queues them for the parse engine.
// -----------------------------------------------------------------------------
module paf_front import paf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	paf_in_if.sink     line_in,
	output tok_t       tok,
	output logic       tok_valid,
	input  logic       tok_ready
);

	tok_t                cls;
	tok_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_AW:0]    cnt_q;
	logic                push;
	logic                pop;
	logic [7:0]          c;

	assign c = line_in.text_byte;

	always_comb begin
		cls            = '0;
		cls.text       = c;
		cls.last       = line_in.line_last;
		cls.is_tab     = (c == CH_TAB);
		cls.is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
		cls.dval       = c[3:0];
		cls.is_space   = (c == CH_SPACE) || ((c >= CH_LF) && (c <= CH_CR));
		cls.is_sign    = (c == CH_PLUS) || (c == CH_MINUS);
		cls.is_minus   = (c == CH_MINUS);
		cls.is_p       = (c == CH_P);
		cls.is_ins     = (c == CH_I);
		cls.is_del     = (c == CH_D);
		cls.first_kind = TAG_NONE;
		if (c == tag_char(TAG_TP, 3'd0))
			cls.first_kind = TAG_TP;
		if (c == tag_char(TAG_CG, 3'd0))
			cls.first_kind = TAG_CG;
		if (c == tag_char(TAG_NM, 3'd0))
			cls.first_kind = TAG_NM;
		if (c == tag_char(TAG_AS, 3'd0))
			cls.first_kind = TAG_AS;
	end

	assign line_in.ready = (cnt_q != (FIFO_AW + 1)'(FIFO_DEPTH));
	assign push          = line_in.valid && line_in.ready;
	assign tok_valid     = (cnt_q != '0);
	assign pop           = tok_valid && tok_ready;
	assign tok           = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- rtl/paf_back.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// paf_back
// Per-byte parse engine: numbers, tag prefixes, CIGAR runs and field capture.
// -----------------------------------------------------------------------------
module paf_back import paf_pkg::*; #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  tok_t        tok,
	input  logic        tok_valid,
	output logic        tok_ready,
	output snap_t       snap,
	output logic        snap_valid,
	input  logic        snap_ready
);

	localparam int MW = NUMBER_WIDTH + 4;

	logic [23:0]              min_sv_q;
	logic [NUMBER_WIDTH-1:0]  acc_q, acc_d;
	logic                     neg_q, neg_d;
	num_phase_t               phase_q, phase_d;
	logic [2:0]               pm_q, pm_d;
	tag_kind_t                kind_q, kind_d;
	logic [31:0]              run_q, run_d;
	logic [15:0]              ins_q, ins_d, del_q, del_d;
	logic                     prim_q, prim_d;
	logic [3:0]               fidx_q, fidx_d;
	logic [30:0]              qlen_q, qlen_d;
	logic signed [31:0]       qstart_q, qstart_d;
	logic signed [31:0]       qend_q, qend_d;
	logic [7:0]               mapq_q, mapq_d;
	logic [30:0]              resid_q, resid_d;
	logic [30:0]              block_q, block_d;
	logic [30:0]              edit_q, edit_d;
	logic signed [31:0]       score_q, score_d;

	logic [MW-1:0]            num_mac;
	logic [NUMBER_WIDTH-1:0]  num_sat;
	logic [35:0]              run_mac;
	logic [31:0]              run_sat;
	logic signed [31:0]       fval;
	logic [2:0]               end_pm;
	tag_kind_t                end_kind;
	logic                     fire;
	snap_t                    snap_d;
	snap_t                    snap_s2;
	logic                     snap_valid_q;

	assign tok_ready = !tok.last || !snap_valid_q || snap_ready;
	assign fire      = tok_valid && tok_ready;

	assign num_mac = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + MW'(tok.dval);
	assign num_sat = (num_mac > MW'({NUMBER_WIDTH{1'b1}})) ? '1 : num_mac[NUMBER_WIDTH-1:0];
	assign run_mac = ({4'b0, run_q} << 3) + ({4'b0, run_q} << 1) + 36'(tok.dval);
	assign run_sat = (run_mac > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : run_mac[31:0];

	always_comb begin
		acc_d    = acc_q;
		neg_d    = neg_q;
		phase_d  = phase_q;
		pm_d     = pm_q;
		kind_d   = kind_q;
		run_d    = run_q;
		ins_d    = ins_q;
		del_d    = del_q;
		prim_d   = prim_q;
		fidx_d   = fidx_q;
		qlen_d   = qlen_q;
		qstart_d = qstart_q;
		qend_d   = qend_q;
		mapq_d   = mapq_q;
		resid_d  = resid_q;
		block_d  = block_q;
		edit_d   = edit_q;
		score_d  = score_q;

		if (tok.is_tab) begin
			fval     = num_value(64'(acc_q), neg_q);
			end_pm   = pm_q;
			end_kind = kind_q;
			pm_d     = PM_IDLE;
			kind_d   = TAG_NONE;
			run_d    = '0;
			acc_d    = '0;
			neg_d    = 1'b0;
			phase_d  = NP_PRE;
		end else begin
			// decimal number
			unique case (phase_q)
				NP_PRE: begin
					if (tok.is_sign) begin
						neg_d   = tok.is_minus;
						phase_d = NP_DIGITS;
					end else if (tok.is_digit) begin
						acc_d   = NUMBER_WIDTH'(tok.dval);
						phase_d = NP_DIGITS;
					end else if (!tok.is_space) begin
						phase_d = NP_STOP;
					end
				end
				NP_DIGITS: begin
					if (tok.is_digit)
						acc_d = num_sat;
					else
						phase_d = NP_STOP;
				end
				default: ;
			endcase

			// tag prefix and value
			priority if (pm_q == PM_IDLE) begin
				if (tok.first_kind != TAG_NONE) begin
					kind_d = tok.first_kind;
					pm_d   = PM_FIRST;
				end else begin
					kind_d = TAG_NONE;
					pm_d   = PM_DEAD;
				end
			end else if (pm_q < PM_VALUE_FIRST) begin
				if (kind_q != TAG_NONE && tag_char(kind_q, pm_q) == tok.text) begin
					pm_d = pm_q + 3'd1;
					if (pm_d == PM_VALUE_FIRST) begin
						if (kind_q == TAG_TP)
							prim_d = 1'b0;
						else if (kind_q == TAG_NM || kind_q == TAG_AS) begin
							acc_d   = '0;
							neg_d   = 1'b0;
							phase_d = NP_PRE;
						end
					end
				end else begin
					pm_d   = PM_DEAD;
					kind_d = TAG_NONE;
				end
			end else if (pm_q != PM_DEAD) begin
				if (pm_q == PM_VALUE_FIRST && kind_q == TAG_TP)
					prim_d = tok.is_p;
				pm_d = PM_VALUE;
				if (kind_q == TAG_CG) begin
					if (tok.is_digit) begin
						run_d = run_sat;
					end else begin
						if (run_q > 32'(min_sv_q)) begin
							if (tok.is_ins && ins_q != 16'hFFFF)
								ins_d = ins_q + 16'd1;
							else if (tok.is_del && del_q != 16'hFFFF)
								del_d = del_q + 16'd1;
						end
						run_d = '0;
					end
				end
			end else begin
			end

			fval     = num_value(64'(acc_d), neg_d);
			end_pm   = pm_d;
			end_kind = kind_d;
		end

		// field end
		if (tok.is_tab || tok.last) begin
			unique case (fidx_q)
				FLD_QLEN:   qlen_d   = clamp31(fval);
				FLD_QSTART: qstart_d = fval;
				FLD_QEND:   qend_d   = fval;
				FLD_RESID:  resid_d  = clamp31(fval);
				FLD_BLOCK:  block_d  = clamp31(fval);
				FLD_MAPQ:   mapq_d   = clamp8(fval);
				default: ;
			endcase
			if (end_pm >= PM_VALUE_FIRST && end_pm != PM_DEAD) begin
				if (end_kind == TAG_NM)
					edit_d = clamp31(fval);
				else if (end_kind == TAG_AS)
					score_d = fval;
			end
			if (fidx_q != MIN_FIELDS)
				fidx_d = fidx_q + 4'd1;
		end

		snap_d.fields_ok = (fidx_d == MIN_FIELDS);
		snap_d.qlen      = qlen_d;
		snap_d.qstart    = qstart_d;
		snap_d.qend      = qend_d;
		snap_d.mapq      = mapq_d;
		snap_d.resid     = resid_d;
		snap_d.block     = block_d;
		snap_d.prim      = prim_d;
		snap_d.ins       = ins_d;
		snap_d.del       = del_d;
		snap_d.edit      = edit_d;
		snap_d.score     = score_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sv_q <= 24'd50;
		end else if (cfg_we) begin
			min_sv_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			neg_q    <= 1'b0;
			phase_q  <= NP_PRE;
			pm_q     <= PM_IDLE;
			kind_q   <= TAG_NONE;
			run_q    <= '0;
			ins_q    <= '0;
			del_q    <= '0;
			prim_q   <= 1'b1;
			fidx_q   <= '0;
			qlen_q   <= '0;
			qstart_q <= '0;
			qend_q   <= '0;
			mapq_q   <= '0;
			resid_q  <= '0;
			block_q  <= '0;
			edit_q   <= '0;
			score_q  <= '0;
		end else if (fire) begin
			if (tok.last) begin
				acc_q    <= '0;
				neg_q    <= 1'b0;
				phase_q  <= NP_PRE;
				pm_q     <= PM_IDLE;
				kind_q   <= TAG_NONE;
				run_q    <= '0;
				ins_q    <= '0;
				del_q    <= '0;
				prim_q   <= 1'b1;
				fidx_q   <= '0;
				qlen_q   <= '0;
				qstart_q <= '0;
				qend_q   <= '0;
				mapq_q   <= '0;
				resid_q  <= '0;
				block_q  <= '0;
				edit_q   <= '0;
				score_q  <= '0;
			end else begin
				acc_q    <= acc_d;
				neg_q    <= neg_d;
				phase_q  <= phase_d;
				pm_q     <= pm_d;
				kind_q   <= kind_d;
				run_q    <= run_d;
				ins_q    <= ins_d;
				del_q    <= del_d;
				prim_q   <= prim_d;
				fidx_q   <= fidx_d;
				qlen_q   <= qlen_d;
				qstart_q <= qstart_d;
				qend_q   <= qend_d;
				mapq_q   <= mapq_d;
				resid_q  <= resid_d;
				block_q  <= block_d;
				edit_q   <= edit_d;
				score_q  <= score_d;
			end
		end
	end

	// line snapshot, one per completed line
	always_ff @(posedge clk) begin
		if (fire && tok.last)
			snap_s2 <= snap_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			snap_valid_q <= 1'b0;
		else if (fire && tok.last)
			snap_valid_q <= 1'b1;
		else if (snap_ready)
			snap_valid_q <= 1'b0;
	end

	assign snap       = snap_s2;
	assign snap_valid = snap_valid_q;

endmodule

// ----- rtl/paf_result.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// paf_result
// Checks a finished line, forms the record and holds it in the output register.
// -----------------------------------------------------------------------------
module paf_result import paf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  snap_t  snap,
	input  logic   snap_valid,
	output logic   snap_ready,
	paf_out_if.source rec_out
);

	logic signed [32:0] diff;
	logic [31:0]        aligned;
	logic [16:0]        sv_sum;
	logic [15:0]        sv;
	status_t            st;
	logic               ok;
	logic               load;
	logic               out_valid_q;

	logic [1:0]         status_q;
	logic [30:0]        qlen_q;
	logic [31:0]        aligned_q;
	logic [7:0]         mapq_q;
	logic [30:0]        resid_q;
	logic [30:0]        block_q;
	logic               prim_q;
	logic [15:0]        sv_q;
	logic [15:0]        ins_q;
	logic [15:0]        del_q;
	logic [30:0]        edit_q;
	logic [31:0]        score_q;

	assign diff    = {snap.qend[31], snap.qend} - {snap.qstart[31], snap.qstart};
	assign aligned = (diff[32] != diff[31]) ? (diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
		: diff[31:0];
	assign sv_sum  = {1'b0, snap.ins} + {1'b0, snap.del};
	assign sv      = sv_sum[16] ? 16'hFFFF : sv_sum[15:0];

	always_comb begin
		priority if (!snap.fields_ok)
			st = ST_SHORT;
		else if (snap.qstart == '0 && snap.qend == '0)
			st = ST_ZERO_POS;
		else
			st = ST_OK;
	end

	assign ok         = (st == ST_OK);
	assign snap_ready = !out_valid_q || rec_out.ready;
	assign load       = snap_valid && snap_ready;

	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= st;
			qlen_q    <= ok ? snap.qlen  : '0;
			aligned_q <= ok ? aligned    : '0;
			mapq_q    <= ok ? snap.mapq  : '0;
			resid_q   <= ok ? snap.resid : '0;
			block_q   <= ok ? snap.block : '0;
			prim_q    <= ok ? snap.prim  : 1'b0;
			sv_q      <= ok ? sv         : '0;
			ins_q     <= ok ? snap.ins   : '0;
			del_q     <= ok ? snap.del   : '0;
			edit_q    <= ok ? snap.edit  : '0;
			score_q   <= ok ? snap.score : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (rec_out.ready)
			out_valid_q <= 1'b0;
	end

	assign rec_out.valid           = out_valid_q;
	assign rec_out.status          = status_q;
	assign rec_out.query_length    = qlen_q;
	assign rec_out.aligned_span    = aligned_q;
	assign rec_out.mapping_quality = mapq_q;
	assign rec_out.residue_matches = resid_q;
	assign rec_out.block_length    = block_q;
	assign rec_out.primary         = prim_q;
	assign rec_out.variant_total   = sv_q;
	assign rec_out.ins_runs        = ins_q;
	assign rec_out.del_runs        = del_q;
	assign rec_out.edit_distance   = edit_q;
	assign rec_out.alignment_score = score_q;

endmodule

// ----- rtl/paf_line_sv_parser.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// paf_line_sv_parser
// PAF alignment line parser: one text byte per cycle in unless stalled, one record per line out.
// -----------------------------------------------------------------------------
// Throughput: one byte per cycle, except that a line's last byte waits while the previous snapshot is not taken.
// Path: after the transfer of the line's last byte the record passes the byte queue, then
// the snapshot and record registers, and waits there while the output is stalled.
// A record waiting at the output does not stop the following line's bytes.
// Reset: clears the byte queue, the line state and the output; min_sv_length returns to 50.
module paf_line_sv_parser import paf_pkg::*; #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	paf_in_if.sink      line_in,
	paf_out_if.source   rec_out
);

	tok_t  tok;
	logic  tok_valid;
	logic  tok_ready;
	snap_t snap;
	logic  snap_valid;
	logic  snap_ready;

	paf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_in   (line_in),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready)
	);

	paf_back #(
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.tok        (tok),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.snap       (snap),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready)
	);

	paf_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap       (snap),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.rec_out    (rec_out)
	);

endmodule

// ----- rtl/paf_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// paf_checker
// Port-level assertions on the record output of the PAF line parser.
// -----------------------------------------------------------------------------
module paf_checker import paf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [30:0]        query_length,
	input logic signed [31:0] aligned_span,
	input logic [7:0]         mapping_quality,
	input logic [30:0]        residue_matches,
	input logic [30:0]        block_length,
	input logic               primary,
	input logic [15:0]        variant_total,
	input logic [15:0]        ins_runs,
	input logic [15:0]        del_runs,
	input logic [30:0]        edit_distance,
	input logic signed [31:0] alignment_score
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(query_length) && $stable(aligned_span) && $stable(variant_total))
		else $error("record changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> query_length == '0 && aligned_span == '0 &&
		mapping_quality == '0 && residue_matches == '0 && block_length == '0 &&
		!primary && variant_total == '0 && ins_runs == '0 && del_runs == '0 &&
		edit_distance == '0 && alignment_score == '0)
		else $error("error record carries data");

	a_sv_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((({1'b0, ins_runs} + {1'b0, del_runs}) > 17'd65535) ?
		(variant_total == 16'hFFFF) : (variant_total == ins_runs + del_runs)))
		else $error("variant_total differs from ins_runs plus del_runs");

endmodule

bind paf_line_sv_parser paf_checker u_paf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (rec_out.valid),
	.out_ready       (rec_out.ready),
	.status          (rec_out.status),
	.query_length    (rec_out.query_length),
	.aligned_span    (rec_out.aligned_span),
	.mapping_quality (rec_out.mapping_quality),
	.residue_matches (rec_out.residue_matches),
	.block_length    (rec_out.block_length),
	.primary         (rec_out.primary),
	.variant_total   (rec_out.variant_total),
	.ins_runs        (rec_out.ins_runs),
	.del_runs        (rec_out.del_runs),
	.edit_distance   (rec_out.edit_distance),
	.alignment_score (rec_out.alignment_score)
);

// ----- sim/tb_paf_line_sv_parser.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_paf_line_sv_parser
// Streams PAF text lines into the parser byte by byte and predicts each line's
// record: fixed numeric fields, tag values and long indel counts. Records are
// checked field by field in order, under varying SV thresholds and with random
// gaps on the byte side and stalls on the record side.
// -----------------------------------------------------------------------------
module tb_paf_line_sv_parser;
	import paf_pkg::*;

	localparam int              NUM_W    = 32;
	localparam longint unsigned NUM_MAX  = (64'd1 << NUM_W) - 64'd1;
	localparam longint          LIMIT_NS = 4_000_000;

	typedef struct packed {
		status_t            status;
		logic [30:0]        qlen;
		logic signed [31:0] aligned;
		logic [7:0]         mapq;
		logic [30:0]        resid;
		logic [30:0]        blen;
		logic               prim;
		logic [15:0]        sv;
		logic [15:0]        ins;
		logic [15:0]        del;
		logic [30:0]        edit;
		logic signed [31:0] score;
	} rec_t;

	class paf_record_board;
		rec_t            records_due[$];
		int              errors;
		logic [23:0]     threshold;
		string           tag_names[4];
		logic [15:0]     fidx;
		logic [2:0]      pm;
		tag_kind_t       kind;
		longint unsigned acc;
		bit              neg;
		num_phase_t      np;
		logic [31:0]     run;
		longint          qlen, qstart, qend, mapq, resid, blen, edit, score;
		int              ins, del;
		bit              prim;

		function new();
			errors = 0;
			threshold = 24'd50;
			tag_names = '{"tp:A:", "cg:Z:", "NM:i:", "AS:i:"};
			line_clear();
		endfunction

		function void num_restart();
			acc = 0;
			neg = 1'b0;
			np = NP_PRE;
		endfunction

		function void field_open();
			pm = PM_IDLE;
			kind = TAG_NONE;
			run = '0;
			num_restart();
		endfunction

		function void line_clear();
			fidx = '0;
			field_open();
			qlen = 0; qstart = 0; qend = 0; mapq = 0;
			resid = 0; blen = 0; edit = 0; score = 0;
			ins = 0; del = 0;
			prim = 1'b1;
		endfunction

		function longint num_val();
			longint unsigned m;
			m = acc;
			if (neg) begin
				if (m > 64'd2147483648)
					m = 64'd2147483648;
				return -longint'(m);
			end
			if (m > 64'd2147483647)
				m = 64'd2147483647;
			return longint'(m);
		endfunction

		function longint clip(longint v, longint hi);
			if (v < 0)
				return 0;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void number_char(logic [7:0] c);
			bit              dig;
			longint unsigned d;
			dig = (c >= CH_ZERO && c <= CH_NINE);
			d = c - CH_ZERO;
			case (np)
				NP_PRE: begin
					if (c == CH_SPACE || (c >= CH_LF && c <= CH_CR))
						return;
					if (c == CH_PLUS || c == CH_MINUS) begin
						neg = (c == CH_MINUS);
						np = NP_DIGITS;
					end else if (dig) begin
						acc = d;
						np = NP_DIGITS;
					end else begin
						np = NP_STOP;
					end
				end
				NP_DIGITS: begin
					if (!dig)
						np = NP_STOP;
					else if (acc > (NUM_MAX - d) / 10)
						acc = NUM_MAX;
					else
						acc = acc * 10 + d;
				end
				default: ;
			endcase
		endfunction

		function void cigar_char(logic [7:0] c);
			logic [31:0] d;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = 32'(c - CH_ZERO);
				if (run > (32'hFFFF_FFFF - d) / 10)
					run = 32'hFFFF_FFFF;
				else
					run = run * 10 + d;
				return;
			end
			if (run > 32'(threshold)) begin
				if (c == CH_I && ins < 65535)
					ins++;
				else if (c == CH_D && del < 65535)
					del++;
			end
			run = '0;
		endfunction

		function void prefix_char(logic [7:0] c);
			if (pm == PM_IDLE) begin
				pm = PM_DEAD;
				for (int k = 0; k < 4; k++) begin
					if (tag_names[k][0] == c) begin
						kind = tag_kind_t'(k + 1);
						pm = PM_FIRST;
					end
				end
				return;
			end
			if (pm < PM_VALUE_FIRST) begin
				if (kind != TAG_NONE && tag_names[int'(kind) - 1][pm] == c) begin
					pm++;
					if (pm == PM_VALUE_FIRST) begin
						if (kind == TAG_TP)
							prim = 1'b0;
						else if (kind == TAG_NM || kind == TAG_AS)
							num_restart();
					end
				end else begin
					pm = PM_DEAD;
					kind = TAG_NONE;
				end
				return;
			end
			if (pm == PM_VALUE_FIRST) begin
				if (kind == TAG_TP)
					prim = (c == CH_P);
				pm = PM_VALUE;
			end
			if (pm == PM_VALUE && kind == TAG_CG)
				cigar_char(c);
		endfunction

		function void field_close();
			longint v;
			v = num_val();
			case (fidx)
				FLD_QLEN:   qlen = v;
				FLD_QSTART: qstart = v;
				FLD_QEND:   qend = v;
				FLD_RESID:  resid = v;
				FLD_BLOCK:  blen = v;
				FLD_MAPQ:   mapq = v;
				default: ;
			endcase
			if (pm >= PM_VALUE_FIRST && pm != PM_DEAD) begin
				if (kind == TAG_NM)
					edit = v;
				else if (kind == TAG_AS)
					score = v;
			end
			if (fidx != 16'hFFFF)
				fidx++;
		endfunction

		function void note_byte(logic [7:0] c, logic lst);
			rec_t   r;
			longint al;
			int     s;
			if (c == CH_TAB) begin
				field_close();
				field_open();
			end else begin
				number_char(c);
				prefix_char(c);
			end
			if (!lst)
				return;
			if (c != CH_TAB)
				field_close();
			r = '0;
			if (fidx < MIN_FIELDS) begin
				r.status = ST_SHORT;
			end else if (qstart == 0 && qend == 0) begin
				r.status = ST_ZERO_POS;
			end else begin
				al = qend - qstart;
				if (al > 64'sd2147483647)
					al = 64'sd2147483647;
				if (al < -64'sd2147483648)
					al = -64'sd2147483648;
				s = ins + del;
				if (s > 65535)
					s = 65535;
				r.status = ST_OK;
				r.qlen = 31'(clip(qlen, 2147483647));
				r.aligned = 32'(al);
				r.mapq = 8'(clip(mapq, 255));
				r.resid = 31'(clip(resid, 2147483647));
				r.blen = 31'(clip(blen, 2147483647));
				r.prim = prim;
				r.sv = 16'(s);
				r.ins = 16'(ins);
				r.del = 16'(del);
				r.edit = 31'(clip(edit, 2147483647));
				r.score = 32'(score);
			end
			records_due.insert(records_due.size(), r);
			line_clear();
		endfunction

		function void same(string name, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_record(rec_t got);
			rec_t want;
			if (records_due.size() == 0) begin
				$error("record with no line pending, status %0d", got.status);
				errors++;
				return;
			end
			want = records_due.pop_front();
			same("status", want.status, got.status);
			same("query_length", want.qlen, got.qlen);
			same("aligned_span", want.aligned, got.aligned);
			same("mapping_quality", want.mapq, got.mapq);
			same("residue_matches", want.resid, got.resid);
			same("block_length", want.blen, got.blen);
			same("primary", want.prim, got.prim);
			same("variant_total", want.sv, got.sv);
			same("ins_runs", want.ins, got.ins);
			same("del_runs", want.del, got.del);
			same("edit_distance", want.edit, got.edit);
			same("alignment_score", want.score, got.score);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [23:0] cfg_wdata;

	paf_in_if  line_if ();
	paf_out_if rec_if ();

	paf_record_board board;
	rec_t            seen;
	logic [7:0]      line_buf[$];
	int unsigned     src_idle_pct;
	int unsigned     snk_stall_pct;
	int unsigned     bytes_sent;

	paf_line_sv_parser #(.NUMBER_WIDTH(NUM_W)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.line_in   (line_if),
		.rec_out   (rec_if)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rec_if.valid && rec_if.ready) begin
			seen.status = status_t'(rec_if.status);
			seen.qlen = rec_if.query_length;
			seen.aligned = rec_if.aligned_span;
			seen.mapq = rec_if.mapping_quality;
			seen.resid = rec_if.residue_matches;
			seen.blen = rec_if.block_length;
			seen.prim = rec_if.primary;
			seen.sv = rec_if.variant_total;
			seen.ins = rec_if.ins_runs;
			seen.del = rec_if.del_runs;
			seen.edit = rec_if.edit_distance;
			seen.score = rec_if.alignment_score;
			board.check_record(seen);
		end
		rec_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	function automatic void add_byte(logic [7:0] b);
		line_buf.insert(line_buf.size(), b);
	endfunction

	function automatic void put(string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.insert(line_buf.size(), s[i]);
	endfunction

	function automatic string num_text();
		string core;
		core = $sformatf("%0d", $urandom_range(0, 999));
		case ($urandom_range(0, 11))
			0: return $sformatf("%0d", $urandom);
			1: return $sformatf("%0d%0d", $urandom, $urandom_range(0, 99999));
			2: return {"-", core};
			3: return {"+", core};
			4: return {" \r", core};
			5: return {core, "x5"};
			6: return "";
			7: return {"NM:i:", core};
			8: return {"AS:i:-", core};
			9: return {"-", $sformatf("%0d", $urandom)};
			default: return core;
		endcase
	endfunction

	function automatic void put_cigar();
		int unsigned t, n;
		string       ops;
		t = board.threshold;
		ops = "MIDNSHP=X";
		repeat ($urandom_range(1, 5)) begin
			case ($urandom_range(0, 5))
				0: n = $urandom_range(0, 9);
				1: n = t;
				2: n = t + 1;
				3: n = (t == 0) ? 0 : t - 1;
				4: n = $urandom_range(0, 300);
				default: n = $urandom;
			endcase
			if ($urandom_range(0, 9) == 0)
				put("99999999999");
			else if ($urandom_range(0, 9) != 0)
				put($sformatf("%0d", n));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: put("I");
				4, 5, 6: put("D");
				7: add_byte(8'($urandom_range(0, 255)));
				default: add_byte(ops[$urandom_range(0, 8)]);
			endcase
		end
		if ($urandom_range(0, 4) == 0)
			put($sformatf("%0d", $urandom_range(0, 999)));
	endfunction

	function automatic void put_tag();
		case ($urandom_range(0, 9))
			0, 1: begin
				put("tp:A:");
				case ($urandom_range(0, 3))
					0: put("P");
					1: put("S");
					2: ;
					default: add_byte(8'($urandom_range(0, 255)));
				endcase
			end
			2, 3, 4: begin
				put("cg:Z:");
				put_cigar();
			end
			5: put({"NM:i:", num_text()});
			6: put({"AS:i:", num_text()});
			7: begin
				case ($urandom_range(0, 4))
					0: put("tp:A");
					1: put("cg:z:60I");
					2: put("NM:I:3");
					3: put("AS:i");
					default: put("Ntp:A:S");
				endcase
			end
			8: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
			default: put({"zz:i:", num_text()});
		endcase
	endfunction

	function automatic void make_record_line();
		put($sformatf("q%0d\t", $urandom_range(0, 9)));
		put({num_text(), "\t"});
		if ($urandom_range(0, 9) == 0)
			put("0\t0\t");
		else
			put({num_text(), "\t", num_text(), "\t"});
		if ($urandom_range(0, 1) != 0)
			put("+\tt\t");
		else
			put("-\tt\t");
		put($sformatf("%0d\t%0d\t%0d\t", $urandom_range(0, 9), $urandom_range(0, 9),
			$urandom_range(0, 9)));
		put({num_text(), "\t", num_text(), "\t", num_text()});
		repeat ($urandom_range(0, 4)) begin
			put("\t");
			put_tag();
		end
		if ($urandom_range(0, 9) == 0)
			put("\t");
	endfunction

	function automatic void make_broken_line();
		int unsigned nf;
		nf = $urandom_range(1, 14);
		for (int i = 0; i < nf; i++) begin
			case ($urandom_range(0, 2))
				0: put(num_text());
				1: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
				default: put_tag();
			endcase
			if (i + 1 < nf)
				put("\t");
		end
		if (line_buf.size() == 0)
			add_byte(8'($urandom_range(0, 255)));
	endfunction

	task automatic send_byte(logic [7:0] b, logic lst);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			line_if.valid <= 1'b0;
			@(posedge clk);
		end
		line_if.valid <= 1'b1;
		line_if.text_byte <= b;
		line_if.line_last <= lst;
		do
			@(posedge clk);
		while (!line_if.ready);
		board.note_byte(b, lst);
		bytes_sent++;
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_byte(line_buf[i], i == line_buf.size() - 1);
		line_buf.delete();
	endtask

	task automatic hold_for_records();
		line_if.valid <= 1'b0;
		while (board.records_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		hold_for_records();
		repeat (8) @(posedge clk);
	endtask

	task automatic set_threshold(logic [23:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.threshold = v;
	endtask

	function automatic logic [23:0] pick_threshold(int p);
		case (p)
			1: return 24'd0;
			2: return 24'hFF_FFFF;
			3: return 24'($urandom_range(1, 9));
			4: return 24'($urandom_range(10, 200));
			5: return 24'd50;
			6: return 24'($urandom_range(0, 16777215));
			default: return 24'd0;
		endcase
	endfunction

	initial begin
		int unsigned nb0;
		int          lines;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		line_if.valid = 1'b0;
		line_if.text_byte = '0;
		line_if.line_last = 1'b0;
		rec_if.ready = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		bytes_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short lines, single byte, lone tab
		put("a\tb");
		send_line();
		put("x");
		send_line();
		put("\t");
		send_line();
		// start and end both zero
		put("r\t10\t0\t0\t+\tt\t1\t0\t1\t5\t6\t7");
		send_line();
		// saturating numbers, largest span, long indels at the default threshold
		put("r\t99999999999\t-99999999999\t99999999999\t+\tt\t1\t0\t1\t");
		put("99999999999\t99999999999\t300\ttp:A:P\tcg:Z:51I51D50I50D3M99999999999I12\t");
		put("NM:i:99999999999\tAS:i:99999999999");
		send_line();
		// negative extremes, non-primary, line ends on a tab
		put("r\t-5\t2147483647\t-2147483648\t-\tt\t1\t0\t1\t-7\t-8\t-9\t");
		put("tp:A:S\tNM:i:-4\tAS:i:-99999999999\t");
		send_line();
		// leading spaces, bad signs, tags in numeric fields, repeated tags
		put("r\t ");
		add_byte(8'h0B);
		add_byte(8'h0C);
		put("+12abc\t--3\tNM:i:7\t+\tt\t1\t0\t1\t");
		put("AS:i:-20\t\t+\ttp:A:\tNM:i:1\tNM:i:2\tAS:i:5\tAS:i:x\tcg:Z:60I\tcg:Z:70D5\tcg:Z:I55");
		send_line();
		put("r\t1\t1\t2\t+\tt\t1\t0\t1\t1\t1\t1\ttp:A:S\ttp:A:Px\txtp:A:S\ttp:a:S\tNMi:3\t  AS:i:4");
		send_line();
		// many empty fields past the twelfth
		put("r\t1\t0\t9");
		repeat (20) add_byte(CH_TAB);
		send_line();

		for (int p = 0; p < 8; p++) begin
			if (p != 0)
				set_threshold(pick_threshold(p));
			case (p % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 78; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 78; end
				default: begin src_idle_pct = 18; snk_stall_pct = 18; end
			endcase
			nb0 = bytes_sent;
			lines = 0;
			while (bytes_sent - nb0 < 85 || lines < 2) begin
				if ($urandom_range(0, 9) < 8)
					make_record_line();
				else
					make_broken_line();
				send_line();
				lines++;
				if (lines == 1)
					hold_for_records();
			end
		end

		wait_idle();
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule
